// ----- design/srlb_pkg.sv -----
// shared types and constants for the stereo biquad
// no dependencies
`timescale 1ns / 1ps

package srlb_pkg;

    // coefficient registers are signed q3.20, fixed at 24 bits
    localparam int COEF_BITS = 24;
    localparam int CFG_IDX_BITS = 3;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_A_OUTER   = 3'd0,
        CFG_A_MIDDLE  = 3'd1,
        CFG_B_FIRST   = 3'd2,
        CFG_B_SECOND  = 3'd3,
        CFG_STEREO    = 3'd4
    } t_cfg_idx;

    // per-lane pipeline strobes from the top-level control
    typedef struct packed {
        logic take;     // frame transfer: shift input history, load products
        logic load;     // products move into the feedforward sum stage
        logic commit;   // result leaves for the output register, update output history
    } t_lane_ctl;

endpackage

// ----- design/srlb_frame_if.sv -----
// input channel: one stereo frame per transfer
// depends on nothing
`timescale 1ns / 1ps

interface srlb_frame_if #(
    parameter int SAMPLE_BITS = 24
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_sample;
    logic signed [SAMPLE_BITS-1:0] right_sample;

    modport source (output valid, output left_sample, output right_sample, input ready);
    modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

// ----- design/srlb_result_if.sv -----
// output channel: one filtered stereo frame per transfer
// depends on nothing
`timescale 1ns / 1ps

interface srlb_result_if #(
    parameter int SAMPLE_BITS = 24
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
    logic                          left_clipped;
    logic                          right_clipped;

    modport source (output valid, output left_out, output right_out,
                    output left_clipped, output right_clipped, input ready);
    modport sink   (input valid, input left_out, input right_out,
                    input left_clipped, input right_clipped, output ready);
endinterface

// ----- design/srlb_lane.sv -----
// one channel of the direct-form-1 biquad: history, products, sum, round, clamp
// depends on srlb_pkg
`timescale 1ns / 1ps

module srlb_lane #(
    parameter int SAMPLE_BITS    = 24,
    parameter int COEF_FRAC_BITS = 20
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  srlb_pkg::t_lane_ctl                   i_ctl,
    input  logic signed [SAMPLE_BITS-1:0]         i_sample,
    input  logic signed [srlb_pkg::COEF_BITS-1:0] i_coef_a_outer,
    input  logic signed [srlb_pkg::COEF_BITS-1:0] i_coef_a_middle,
    input  logic signed [srlb_pkg::COEF_BITS-1:0] i_coef_b_first,
    input  logic signed [srlb_pkg::COEF_BITS-1:0] i_coef_b_second,
    output logic signed [SAMPLE_BITS-1:0]         o_y,
    output logic                                  o_clipped
);

    localparam int PW = SAMPLE_BITS + srlb_pkg::COEF_BITS;
    localparam int AW = PW + 3;
    localparam logic signed [AW-1:0] HALF =
        signed'({{(AW-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1));
    localparam logic signed [AW-1:0] SAT_HI =
        signed'({{(AW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}});
    localparam logic signed [AW-1:0] SAT_LO = ~SAT_HI;

    logic signed [SAMPLE_BITS-1:0] r_x1, r_x2, r_y1, r_y2;
    logic signed [PW-1:0]          r_pa0, r_pm1, r_pa2, r_p2;
    logic signed [AW-1:0]          r_ff;

    logic signed [PW-1:0]          n_pa0, n_pm1, n_pa2, n_p2, m_b1;
    logic signed [SAMPLE_BITS-1:0] p2_src;
    logic signed [AW-1:0]          acc, biased, shifted;

    assign n_pa0 = i_coef_a_outer * i_sample;
    assign n_pm1 = i_coef_a_middle * r_x1;
    assign n_pa2 = i_coef_a_outer * r_x2;

    // b2*y2 is kept ready one item ahead; it tracks y2 while idle
    assign p2_src = i_ctl.commit ? r_y1 : r_y2;
    assign n_p2   = i_coef_b_second * p2_src;
    assign m_b1   = i_coef_b_first * r_y1;

    always_comb begin
        acc     = r_ff - AW'(m_b1) - AW'(r_p2);
        biased  = acc + HALF;
        shifted = biased >>> COEF_FRAC_BITS;
        o_clipped = 1'b0;
        if (shifted > SAT_HI) begin
            o_y       = SAT_HI[SAMPLE_BITS-1:0];
            o_clipped = 1'b1;
        end else if (shifted < SAT_LO) begin
            o_y       = SAT_LO[SAMPLE_BITS-1:0];
            o_clipped = 1'b1;
        end else begin
            o_y = shifted[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x1 <= '0;
            r_x2 <= '0;
            r_y1 <= '0;
            r_y2 <= '0;
            r_p2 <= '0;
        end else begin
            r_p2 <= n_p2;
            if (i_ctl.take) begin
                r_x1 <= i_sample;
                r_x2 <= r_x1;
            end
            if (i_ctl.commit) begin
                r_y1 <= o_y;
                r_y2 <= r_y1;
            end
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        if (i_ctl.take) begin
            r_pa0 <= n_pa0;
            r_pm1 <= n_pm1;
            r_pa2 <= n_pa2;
        end
        if (i_ctl.load) begin
            r_ff <= AW'(r_pa0) + AW'(r_pm1) + AW'(r_pa2);
        end
    end

endmodule

// ----- design/stereo_resonant_lowpass_biquad.sv -----
// top level of the stereo direct-form-1 biquad: config registers, stage control,
// two channel lanes and the merging output register
// depends on srlb_pkg, srlb_frame_if, srlb_result_if, srlb_lane
`timescale 1ns / 1ps

//  channel     dir  fields                                               transfer
//  i_frame     in   left_sample, right_sample                            valid & ready
//  o_result    out  left_out, right_out, left_clipped, right_clipped     valid & ready
//  i_cfg_*     in   i_cfg_idx, i_cfg_data                                i_cfg_we
//
//  one frame per cycle sustained while results are taken; a result becomes valid in the
//  output register after the product stage (loaded at the transfer) and the feedforward sum stage
//  the output recursion (b1*y1 multiply, add, round, clamp) is one combinational path,
//  which sets the clock; b2*y2 is precomputed one item ahead
//  synchronous active-low reset clears the delay lines, coefficients and stage valids;
//  stereo mode resets to 1
//  a stalled output holds; upstream stages keep filling bubbles and i_frame.ready
//  drops only when every stage is occupied and the result is not taken

module stereo_resonant_lowpass_biquad #(
    parameter int SAMPLE_BITS    = 24,
    parameter int COEF_FRAC_BITS = 20
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    srlb_frame_if.sink                               i_frame,
    srlb_result_if.source                            o_result,
    input  logic                                     i_cfg_we,
    input  logic [srlb_pkg::CFG_IDX_BITS-1:0]        i_cfg_idx,
    input  logic [srlb_pkg::COEF_BITS-1:0]           i_cfg_data
);

    // configuration registers
    logic signed [srlb_pkg::COEF_BITS-1:0] r_coef_a_outer, r_coef_a_middle;
    logic signed [srlb_pkg::COEF_BITS-1:0] r_coef_b_first, r_coef_b_second;
    logic                                  r_stereo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_a_outer  <= '0;
            r_coef_a_middle <= '0;
            r_coef_b_first  <= '0;
            r_coef_b_second <= '0;
            r_stereo        <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                srlb_pkg::CFG_A_OUTER:  r_coef_a_outer  <= signed'(i_cfg_data);
                srlb_pkg::CFG_A_MIDDLE: r_coef_a_middle <= signed'(i_cfg_data);
                srlb_pkg::CFG_B_FIRST:  r_coef_b_first  <= signed'(i_cfg_data);
                srlb_pkg::CFG_B_SECOND: r_coef_b_second <= signed'(i_cfg_data);
                srlb_pkg::CFG_STEREO:   r_stereo        <= i_cfg_data[0];
                default: begin
                    // unknown index, write dropped
                end
            endcase
        end
    end

    // stage valids and per-stage advance
    logic r_v1, r_v2, r_out_valid;
    logic n_v1, n_v2, n_out_valid;
    logic en_out, en2, en1, accept, load2, commit;

    assign en_out = !r_out_valid || o_result.ready;
    assign en2    = !r_v2 || en_out;
    assign en1    = !r_v1 || en2;
    assign i_frame.ready = en1;

    assign accept = i_frame.valid && en1;
    assign load2  = r_v1 && en2;
    assign commit = r_v2 && en_out;

    assign n_v1        = accept || (r_v1 && !en2);
    assign n_v2        = load2 || (r_v2 && !en_out);
    assign n_out_valid = commit || (r_out_valid && !o_result.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_v1        <= n_v1;
            r_v2        <= n_v2;
            r_out_valid <= n_out_valid;
        end
    end

    // lanes; the right lane holds its history in mono mode
    srlb_pkg::t_lane_ctl ctl_left, ctl_right;

    assign ctl_left.take    = accept;
    assign ctl_left.load    = load2;
    assign ctl_left.commit  = commit;
    assign ctl_right.take   = accept && r_stereo;
    assign ctl_right.load   = load2;
    assign ctl_right.commit = commit && r_stereo;

    logic signed [SAMPLE_BITS-1:0] y_left, y_right;
    logic                          clip_left, clip_right;

    srlb_lane #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_lane_left (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (ctl_left),
        .i_sample        (i_frame.left_sample),
        .i_coef_a_outer  (r_coef_a_outer),
        .i_coef_a_middle (r_coef_a_middle),
        .i_coef_b_first  (r_coef_b_first),
        .i_coef_b_second (r_coef_b_second),
        .o_y             (y_left),
        .o_clipped       (clip_left)
    );

    srlb_lane #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_lane_right (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (ctl_right),
        .i_sample        (i_frame.right_sample),
        .i_coef_a_outer  (r_coef_a_outer),
        .i_coef_a_middle (r_coef_a_middle),
        .i_coef_b_first  (r_coef_b_first),
        .i_coef_b_second (r_coef_b_second),
        .o_y             (y_right),
        .o_clipped       (clip_right)
    );

    // merging output register: right channel forced to zero in mono mode
    logic signed [SAMPLE_BITS-1:0] r_out_left, r_out_right;
    logic                          r_out_lclip, r_out_rclip;

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_out_left  <= y_left;
            r_out_lclip <= clip_left;
            r_out_right <= r_stereo ? y_right : '0;
            r_out_rclip <= r_stereo && clip_right;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.left_out      = r_out_left;
    assign o_result.right_out     = r_out_right;
    assign o_result.left_clipped  = r_out_lclip;
    assign o_result.right_clipped = r_out_rclip;

    // a clipped flag always comes with a full-scale value
    a_left_clip_full_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_lclip) |->
            (r_out_left == {1'b0, {(SAMPLE_BITS-1){1'b1}}} ||
             r_out_left == {1'b1, {(SAMPLE_BITS-1){1'b0}}}))
        else $error("left clip flag without saturated value");

    a_right_clip_full_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_rclip) |->
            (r_out_right == {1'b0, {(SAMPLE_BITS-1){1'b1}}} ||
             r_out_right == {1'b1, {(SAMPLE_BITS-1){1'b0}}}))
        else $error("right clip flag without saturated value");

    // with the output register free, the pipeline never refuses a frame
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> i_frame.ready)
        else $error("input stalled with empty output register");

    // a result leaving the sum stage always lands in the output register
    a_commit_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |=> r_out_valid)
        else $error("committed result lost");

endmodule
